>>> rtl/core/bfac_pkg.sv
// ----------------------------------------------------------------------------
// bfac_pkg - button frame arm controller package
// Widths, request kinds, frame characters and deframer phase codes.
// ----------------------------------------------------------------------------
package bfac_pkg;

  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int PHASE_W = 3;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [PHASE_W-1:0] phase_t;

  // request kinds
  localparam op_t OP_SERIAL  = 2'd0;
  localparam op_t OP_BATT_LO = 2'd1;
  localparam op_t OP_CHARGED = 2'd2;
  localparam op_t OP_MOTION  = 2'd3;

  // frame characters
  localparam byte_t CH_START  = 8'h21;
  localparam byte_t CH_B      = 8'h42;
  localparam byte_t CH_ARM    = 8'h35;
  localparam byte_t CH_DISARM = 8'h36;
  localparam byte_t CH_PRESS  = 8'h31;

  // deframer phases
  localparam phase_t PH_START  = 3'd0;
  localparam phase_t PH_B      = 3'd1;
  localparam phase_t PH_BUTTON = 3'd2;
  localparam phase_t PH_PRESS  = 3'd3;
  localparam phase_t PH_CHECK  = 3'd4;

endpackage

>>> rtl/core/bfac_if.sv
// ----------------------------------------------------------------------------
// bfac_in_if / bfac_out_if - request and result channels
// Valid/ready channels carrying one request or one result each.
// ----------------------------------------------------------------------------
interface bfac_in_if;
  import bfac_pkg::*;

  logic  valid;
  logic  ready;
  op_t   op;
  byte_t rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface bfac_out_if;
  import bfac_pkg::*;

  logic  valid;
  logic  ready;
  logic  armed;
  logic  armable;
  logic  frame_ok;
  byte_t button_code;
  byte_t press_code;
  logic  arm_refused;
  logic  spray_trigger;

  modport source (output valid, output armed, output armable, output frame_ok,
                  output button_code, output press_code, output arm_refused,
                  output spray_trigger, input ready);
  modport sink   (input valid, input armed, input armable, input frame_ok,
                  input button_code, input press_code, input arm_refused,
                  input spray_trigger, output ready);
endinterface

>>> rtl/core/button_frame_arm_controller.sv
// ----------------------------------------------------------------------------
// button_frame_arm_controller - checksummed button frame parser and arm logic
// Deframes '!' 'B' button press checksum, arms/disarms on valid frames,
// tracks battery state and raises a spray trigger on motion while armed.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    op, rx_byte
//  out_ch    out  valid/ready    armed, armable, frame_ok, button_code,
//                                press_code, arm_refused, spray_trigger
//
//  One request per cycle, taken while the output register is empty or being
//  drained; its result appears in the output register on the next cycle.
//  Rate is set by the single output register stage.
//  Reset (rst_n low, synchronous) clears phase, held bytes, flags and valid.
// ----------------------------------------------------------------------------
module button_frame_arm_controller (
  input logic        clk,
  input logic        rst_n,
  bfac_in_if.sink    in_ch,
  bfac_out_if.source out_ch
);
  import bfac_pkg::*;

  phase_t phase_r, phase_nxt;
  byte_t  button_r, button_nxt;
  byte_t  press_r, press_nxt;
  logic   armed_r, armed_nxt;
  logic   armable_r, armable_nxt;
  logic   ok_nxt, refused_nxt, spray_nxt;
  byte_t  chk;
  logic   accept;

  logic   out_vld_r;
  logic   out_ok_r, out_refused_r, out_spray_r;

  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign chk         = ~(CH_START + CH_B + button_r + press_r);

  always_comb begin
    phase_nxt   = phase_r;
    button_nxt  = button_r;
    press_nxt   = press_r;
    armed_nxt   = armed_r;
    armable_nxt = armable_r;
    ok_nxt      = 1'b0;
    refused_nxt = 1'b0;
    spray_nxt   = 1'b0;
    case (in_ch.op)
      OP_SERIAL: begin
        case (phase_r)
          PH_START:  phase_nxt = (in_ch.rx_byte == CH_START) ? PH_B : PH_START;
          PH_B:      phase_nxt = (in_ch.rx_byte == CH_B) ? PH_BUTTON : PH_START;
          PH_BUTTON: begin
            button_nxt = in_ch.rx_byte;
            phase_nxt  = PH_PRESS;
          end
          PH_PRESS: begin
            press_nxt = in_ch.rx_byte;
            phase_nxt = PH_CHECK;
          end
          PH_CHECK: begin
            phase_nxt = PH_START;
            if (in_ch.rx_byte == chk) begin
              ok_nxt = 1'b1;
              if (button_r == CH_ARM && press_r == CH_PRESS) begin
                if (armable_r) armed_nxt = 1'b1;
                else refused_nxt = 1'b1;
              end else if (button_r == CH_DISARM && press_r == CH_PRESS) begin
                armed_nxt = 1'b0;
              end
            end
          end
          default: phase_nxt = PH_START;
        endcase
      end
      OP_BATT_LO: begin
        armed_nxt   = 1'b0;
        armable_nxt = 1'b0;
      end
      OP_CHARGED: armable_nxt = 1'b1;
      OP_MOTION:  spray_nxt   = armed_r;
      default:    phase_nxt   = phase_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      button_r  <= '0;
      press_r   <= '0;
      armed_r   <= 1'b0;
      armable_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        button_r  <= button_nxt;
        press_r   <= press_nxt;
        armed_r   <= armed_nxt;
        armable_r <= armable_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // hold result payload until a new request replaces it
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r      <= ok_nxt;
      out_refused_r <= refused_nxt;
      out_spray_r   <= spray_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.armed         = armed_r;
  assign out_ch.armable       = armable_r;
  assign out_ch.frame_ok      = out_ok_r;
  assign out_ch.button_code   = button_r;
  assign out_ch.press_code    = press_r;
  assign out_ch.arm_refused   = out_refused_r;
  assign out_ch.spray_trigger = out_spray_r;

endmodule

>>> sim/button_frame_arm_controller_tb.sv
// ----------------------------------------------------------------------------
// button_frame_arm_controller_tb - self-checking bench for the arm controller
// Drives serial bytes and battery/motion events through the request channel
// and checks every result against a cycle-free model of the deframer and the
// arm logic. A directed opening covers refusal, arming, spray and disarming,
// then randomised frames, events and noise run with random gaps on both
// channels, one long result stall and drain pauses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_frame_arm_controller_tb;
  import bfac_pkg::*;

  localparam int RANDOM_REQS = 1450;
  localparam int HOLD_AT_REQ = 400;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    op_t   op;
    byte_t rx_byte;
    bit    drain;
  } arm_req_t;

  typedef struct {
    logic  armed;
    logic  armable;
    logic  frame_ok;
    byte_t button_code;
    byte_t press_code;
    logic  arm_refused;
    logic  spray_trigger;
  } arm_result_t;

  logic clk;
  logic rst_n;

  bfac_in_if  in_if ();
  bfac_out_if out_if ();

  button_frame_arm_controller u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  arm_req_t    pending_reqs[$];
  arm_result_t expected_results[$];
  arm_req_t    next_req;

  phase_t model_phase;
  byte_t  model_button;
  byte_t  model_press;
  logic   model_armed;
  logic   model_armable;

  int mismatch_count = 0;
  int reqs_accepted  = 0;
  int tx_gap         = 0;
  int tx_burst       = 0;
  int rx_gap         = 0;
  int rx_burst       = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic arm_result_t predict_arm_result(op_t op, byte_t b);
    arm_result_t r;
    byte_t       sum;
    r.frame_ok      = 1'b0;
    r.arm_refused   = 1'b0;
    r.spray_trigger = 1'b0;
    case (op)
      OP_SERIAL: begin
        case (model_phase)
          PH_START:  model_phase = (b == CH_START) ? PH_B : PH_START;
          PH_B:      model_phase = (b == CH_B) ? PH_BUTTON : PH_START;
          PH_BUTTON: begin
            model_button = b;
            model_phase  = PH_PRESS;
          end
          PH_PRESS: begin
            model_press = b;
            model_phase = PH_CHECK;
          end
          PH_CHECK: begin
            sum = CH_START + CH_B + model_button + model_press;
            if (b == ~sum) begin
              r.frame_ok = 1'b1;
              if (model_button == CH_ARM && model_press == CH_PRESS) begin
                if (model_armable) model_armed = 1'b1;
                else r.arm_refused = 1'b1;
              end else if (model_button == CH_DISARM && model_press == CH_PRESS) begin
                model_armed = 1'b0;
              end
            end
            model_phase = PH_START;
          end
          default: model_phase = PH_START;
        endcase
      end
      OP_BATT_LO: begin
        model_armed   = 1'b0;
        model_armable = 1'b0;
      end
      OP_CHARGED: model_armable = 1'b1;
      default:    r.spray_trigger = model_armed;
    endcase
    r.armed       = model_armed;
    r.armable     = model_armable;
    r.button_code = model_button;
    r.press_code  = model_press;
    return r;
  endfunction

  function automatic int pick_gap(inout int burst_left);
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_req(op_t op, byte_t b, bit drain = 1'b0);
    arm_req_t q;
    q.op      = op;
    q.rx_byte = b;
    q.drain   = drain;
    pending_reqs.push_back(q);
  endtask

  function automatic op_t random_event();
    case ($urandom_range(0, 2))
      0:       return OP_BATT_LO;
      1:       return OP_CHARGED;
      default: return OP_MOTION;
    endcase
  endfunction

  // push one frame; optionally slip an event in after the given byte index
  task automatic add_frame(byte_t btn, byte_t prs, bit good_chk, int event_at = -1,
                           op_t ev = OP_MOTION);
    byte_t bytes[5];
    byte_t sum;
    sum      = CH_START + CH_B + btn + prs;
    bytes[0] = CH_START;
    bytes[1] = CH_B;
    bytes[2] = btn;
    bytes[3] = prs;
    bytes[4] = good_chk ? ~sum : (~sum ^ byte_t'($urandom_range(1, 255)));
    for (int i = 0; i < 5; i++) begin
      add_req(OP_SERIAL, bytes[i]);
      if (i == event_at) add_req(ev, byte_t'($urandom_range(0, 255)));
    end
  endtask

  task automatic report_mismatch(string what, int exp_v, int got_v);
    $display("MISMATCH %s: expected %0h, got %0h at %0t", what, exp_v, got_v, $time);
    mismatch_count++;
  endtask

  task automatic check_result();
    arm_result_t e;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", 0, 1);
      return;
    end
    e = expected_results.pop_front();
    if (out_if.armed !== e.armed) report_mismatch("armed", e.armed, out_if.armed);
    if (out_if.armable !== e.armable)
      report_mismatch("armable", e.armable, out_if.armable);
    if (out_if.frame_ok !== e.frame_ok)
      report_mismatch("frame_ok", e.frame_ok, out_if.frame_ok);
    if (out_if.button_code !== e.button_code)
      report_mismatch("button_code", e.button_code, out_if.button_code);
    if (out_if.press_code !== e.press_code)
      report_mismatch("press_code", e.press_code, out_if.press_code);
    if (out_if.arm_refused !== e.arm_refused)
      report_mismatch("arm_refused", e.arm_refused, out_if.arm_refused);
    if (out_if.spray_trigger !== e.spray_trigger)
      report_mismatch("spray_trigger", e.spray_trigger, out_if.spray_trigger);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(predict_arm_result(in_if.op, in_if.rx_byte));
        reqs_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && expected_results.size() != 0)) begin
          next_req      = pending_reqs.pop_front();
          in_if.valid   <= 1'b1;
          in_if.op      <= next_req.op;
          in_if.rx_byte <= next_req.rx_byte;
          tx_gap        = pick_gap(tx_burst);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_result();
      if (!hold_done && reqs_accepted >= HOLD_AT_REQ) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        rx_gap = pick_gap(rx_burst);
      end
    end
  end

  initial begin
    int    kind;
    byte_t btn;
    byte_t prs;

    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.op      = OP_SERIAL;
    in_if.rx_byte = '0;
    out_if.ready  = 1'b0;

    model_phase   = PH_START;
    model_button  = '0;
    model_press   = '0;
    model_armed   = 1'b0;
    model_armable = 1'b0;

    // motion while disarmed, arm refused, charge, arm with an event mid-frame
    add_req(OP_MOTION, 8'hFF);
    add_frame(CH_ARM, CH_PRESS, 1'b1);
    add_req(OP_CHARGED, 8'h00);
    add_frame(CH_ARM, CH_PRESS, 1'b1, 2, OP_MOTION);
    add_req(OP_MOTION, 8'h5A);
    // bad checksum keeps the held bytes, then a clean disarm
    add_frame(CH_DISARM, CH_PRESS, 1'b0);
    add_frame(CH_DISARM, CH_PRESS, 1'b1);
    add_req(OP_BATT_LO, 8'hA5);
    add_req(OP_SERIAL, 8'hFF);
    add_req(OP_SERIAL, 8'h00);

    add_req(OP_SERIAL, 8'h00, 1'b1);
    while (pending_reqs.size() < RANDOM_REQS + 27) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        case ($urandom_range(0, 3))
          0:       btn = CH_ARM;
          1:       btn = CH_DISARM;
          default: btn = byte_t'($urandom_range(0, 255));
        endcase
        prs = ($urandom_range(0, 3) != 0) ? CH_PRESS : byte_t'($urandom_range(0, 255));
        add_frame(btn, prs, $urandom_range(0, 99) < 85,
                  ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3)) : -1,
                  random_event());
      end else if (kind < 85) begin
        add_req(random_event(), byte_t'($urandom_range(0, 255)),
                $urandom_range(0, 99) == 0);
      end else if (kind < 92) begin
        add_req(OP_SERIAL, byte_t'($urandom_range(0, 255)));
      end else begin
        // broken frame start
        add_req(OP_SERIAL, CH_START);
        if ($urandom_range(0, 1) != 0) add_req(OP_SERIAL, CH_START);
        add_req(OP_SERIAL, ($urandom_range(0, 1) != 0) ? CH_B
                                                        : byte_t'($urandom_range(0, 255)));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
